FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the encoder odometry checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and reset
`define EOK_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("eok assertion failed");

// assertion on the block clock and reset
`define EOK_ASSERT(label, prop) `EOK_ASSERT_CLK(label, clock, reset, prop)

`endif

FILE: sv/eok_pkg.sv
// ----------------------------------------------------------------------------
// eok_pkg
// codes and fixed constants of the encoder odometry core
// ----------------------------------------------------------------------------
package eok_pkg;

   // transaction kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_REVERSE = 2'd0;
   localparam logic [1:0] REG_GEAR    = 2'd1;
   localparam logic [1:0] REG_CIRC    = 2'd2;

   // microseconds per second
   localparam logic [19:0] US_PER_SEC = 20'd1000000;

   // register reset values
   localparam logic [23:0] GEAR_RESET = 24'h010000;
   localparam logic [31:0] CIRC_RESET = 32'h00010000;

endpackage

FILE: sv/encoder_odometry_kalman_core.sv
// start, clear and other non-update transactions go from idle straight to the done state
// an update makes speed, gain and distance divider passes, only the distance pass if dt is 0
// throughput: one transaction at a time, the input stalls until the result is loaded
// the update work is done by one shared restoring divider, one bit per cycle
// reset (synchronous): state, estimate, variance and distance are zero, gear and
// circumference are 1.0, forward direction
// ----------------------------------------------------------------------------
// encoder_odometry_kalman_core
// encoder angle to speed and distance, with scalar kalman smoothing of the speed,
// built around one shared multiplier and one iterative divider
// ----------------------------------------------------------------------------
module encoder_odometry_kalman_core import eok_pkg::*; #(
   parameter int ANGLE_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [ANGLE_BITS-1:0]       req_raw_angle,
   input  logic [31:0]                 req_time_us,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_speed_rps,
   output logic signed [47:0]          rsp_distance,
   output logic signed [ANGLE_BITS:0]  rsp_angle_step,
   output logic                        rsp_zero_interval,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);

   localparam int NW  = ANGLE_BITS + 32 + FRAC_BITS;
   localparam int DVW = 33;
   localparam int MAW = 33;
   localparam int MBW = (FRAC_BITS + 1 > ANGLE_BITS) ? FRAC_BITS + 1 : ANGLE_BITS;
   localparam int PW  = MAW + MBW;
   localparam int CW  = $clog2(NW);
   localparam int SW  = ANGLE_BITS + 1;

   localparam logic [DVW-1:0] R_Q = DVW'(50 * (2 ** FRAC_BITS));
   localparam logic [32:0] Q_Q = 33'(((2 ** FRAC_BITS) + 5) / 10);
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [SW:0] HALF_S = (SW+1)'(2 ** (ANGLE_BITS - 1));
   localparam logic signed [SW:0] FULL_S = (SW+1)'(2 ** ANGLE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_SPD, ST_DIVIDE, ST_DIV_END,
      ST_MUL_ADJ, ST_MUL_P, ST_MUL_DST, ST_DONE
   } state_type;

   typedef enum logic [1:0] {OP_SPD, OP_KAL, OP_DST} op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic                  reverse_ff, reverse_in;
   logic [23:0]           gear_ff, gear_in;
   logic [31:0]           circ_ff, circ_in;
   logic [ANGLE_BITS-1:0] last_angle_ff, last_angle_in;
   logic [31:0]           last_time_ff, last_time_in;
   logic signed [47:0]    dist_ff, dist_in;
   logic signed [31:0]    est_ff, est_in;
   logic [31:0]           p_ff, p_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0]  step_ff, step_in;
   logic [ANGLE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [ANGLE_BITS-1:0] ang_ff, ang_in;
   logic [31:0]           now_ff, now_in;
   logic                  zflag_ff, zflag_in;
   logic signed [31:0]    u_ff, u_in;
   logic [FRAC_BITS:0]    k_ff, k_in;
   logic [NW-1:0]         quot_ff, quot_in;
   logic [DVW-1:0]        rem_ff, rem_in;
   logic [DVW-1:0]        div_ff, div_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   logic signed [31:0]    rsp_speed_ff, rsp_speed_in;
   logic signed [47:0]    rsp_dist_ff, rsp_dist_in;
   logic signed [SW-1:0]  rsp_step_ff, rsp_step_in;
   logic                  rsp_zero_ff, rsp_zero_in;

   // shared multiplier
   logic [MAW-1:0] mul_a;
   logic [MBW-1:0] mul_b;
   logic [PW-1:0]  prod;

   // divider step
   logic [DVW:0]   shifted;
   logic           div_ge;
   logic [DVW:0]   div_sub;

   // step unwrap
   logic signed [SW:0]   raw_diff;
   logic signed [SW:0]   unwrap;
   logic signed [SW-1:0] s_w;
   logic signed [SW-1:0] s_abs;
   logic [31:0]          dt;

   // post-processing
   logic [NW-1:0]        q_shift;
   logic signed [32:0]   diff;
   logic [32:0]          dmag;
   logic [32:0]          adj;
   logic signed [33:0]   est_sum;
   logic [32:0]          np;
   logic [47:0]          res48;
   logic signed [49:0]   delta;
   logic signed [49:0]   dist_sum;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_rps     = rsp_speed_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_angle_step    = rsp_step_ff;
   assign rsp_zero_interval = rsp_zero_ff;

   always_comb begin
      raw_diff = $signed({2'b00, req_raw_angle}) - $signed({2'b00, last_angle_ff});
      if (raw_diff > HALF_S) begin
         unwrap = raw_diff - FULL_S;
      end else if (raw_diff < -HALF_S) begin
         unwrap = raw_diff + FULL_S;
      end else begin
         unwrap = raw_diff;
      end
      s_w   = reverse_ff ? -unwrap[SW-1:0] : unwrap[SW-1:0];
      s_abs = s_w[SW-1] ? -s_w : s_w;
      dt    = req_time_us - last_time_ff;
   end

   always_comb begin
      unique case (state_ff)
         ST_MUL_SPD: begin
            mul_a = MAW'(US_PER_SEC);
            mul_b = MBW'(mag_ff);
         end
         ST_MUL_ADJ: begin
            mul_a = dmag;
            mul_b = MBW'(k_ff);
         end
         ST_MUL_P: begin
            mul_a = MAW'(p_ff);
            mul_b = MBW'(ONE_Q - k_ff);
         end
         default: begin
            mul_a = MAW'(circ_ff);
            mul_b = MBW'(mag_ff);
         end
      endcase
      prod = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      shifted = {rem_ff, quot_ff[NW-1]};
      div_ge  = (shifted >= {1'b0, div_ff});
      div_sub = shifted - {1'b0, div_ff};
      diff    = $signed({u_ff[31], u_ff}) - $signed({est_ff[31], est_ff});
      dmag    = diff[32] ? 33'(-diff) : 33'(diff);
      adj     = prod[FRAC_BITS +: 33];
      est_sum = $signed({{2{est_ff[31]}}, est_ff})
              + (diff[32] ? -$signed({1'b0, adj}) : $signed({1'b0, adj}));
      np      = prod[FRAC_BITS +: 33] + Q_Q;
      q_shift = quot_ff >> ANGLE_BITS;
      res48   = q_shift[47:0];
      delta   = neg_ff ? -$signed({2'b00, res48}) : $signed({2'b00, res48});
      dist_sum = $signed({{2{dist_ff[47]}}, dist_ff}) + delta;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      reverse_in    = reverse_ff;
      gear_in       = gear_ff;
      circ_in       = circ_ff;
      last_angle_in = last_angle_ff;
      last_time_in  = last_time_ff;
      dist_in       = dist_ff;
      est_in        = est_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      ang_in        = ang_ff;
      now_in        = now_ff;
      zflag_in      = zflag_ff;
      u_in          = u_ff;
      k_in          = k_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_zero_in   = rsp_zero_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            REG_REVERSE: reverse_in = csr_wdata[0];
            REG_GEAR:    gear_in    = csr_wdata[23:0];
            REG_CIRC:    circ_in    = csr_wdata;
            default:     ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ang_in   = req_raw_angle;
               now_in   = req_time_us;
               step_in  = '0;
               zflag_in = 1'b0;
               state_in = ST_DONE;
               unique case (req_kind)
                  KIND_START: begin
                     last_angle_in = req_raw_angle;
                     last_time_in  = req_time_us;
                  end
                  KIND_CLEAR: begin
                     dist_in = '0;
                  end
                  KIND_UPDATE: begin
                     step_in = unwrap[SW-1:0];
                     mag_in  = s_abs[ANGLE_BITS-1:0];
                     neg_in  = s_w[SW-1];
                     div_in  = DVW'(dt);
                     if (dt == 32'd0) begin
                        zflag_in = 1'b1;
                        state_in = ST_MUL_DST;
                     end else begin
                        state_in = ST_MUL_SPD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL_SPD: begin
            quot_in  = NW'(prod) << FRAC_BITS;
            rem_in   = '0;
            cnt_in   = CW'(NW - 1);
            op_in    = OP_SPD;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            quot_in = {quot_ff[NW-2:0], div_ge};
            rem_in  = div_ge ? div_sub[DVW-1:0] : shifted[DVW-1:0];
            if (cnt_ff == '0) begin
               state_in = ST_DIV_END;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV_END: begin
            unique case (op_ff)
               OP_SPD: begin
                  if (!neg_ff) begin
                     u_in = (q_shift > NW'(32'h7fffffff)) ? 32'sh7fffffff
                                                          : $signed(q_shift[31:0]);
                  end else begin
                     u_in = (q_shift > NW'(32'h80000000)) ? 32'sh80000000
                                                          : -$signed(q_shift[31:0]);
                  end
                  quot_in  = NW'(p_ff) << FRAC_BITS;
                  rem_in   = '0;
                  div_in   = DVW'(p_ff) + R_Q;
                  cnt_in   = CW'(NW - 1);
                  op_in    = OP_KAL;
                  state_in = ST_DIVIDE;
               end
               OP_KAL: begin
                  k_in     = quot_ff[FRAC_BITS:0];
                  state_in = ST_MUL_ADJ;
               end
               default: begin
                  if (dist_sum > 50'sh007fffffffffff) begin
                     dist_in = 48'sh7fffffffffff;
                  end else if (dist_sum < -50'sh00800000000000) begin
                     dist_in = 48'sh800000000000;
                  end else begin
                     dist_in = dist_sum[47:0];
                  end
                  last_angle_in = ang_ff;
                  last_time_in  = now_ff;
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_MUL_ADJ: begin
            if (est_sum > 34'sd2147483647) begin
               est_in = 32'sh7fffffff;
            end else if (est_sum < -34'sd2147483648) begin
               est_in = 32'sh80000000;
            end else begin
               est_in = est_sum[31:0];
            end
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            p_in     = np[32] ? 32'hffffffff : np[31:0];
            state_in = ST_MUL_DST;
         end
         ST_MUL_DST: begin
            quot_in  = NW'(prod) << FRAC_BITS;
            rem_in   = '0;
            div_in   = (gear_ff == 24'd0) ? DVW'(1) : DVW'(gear_ff);
            cnt_in   = CW'(NW - 1);
            op_in    = OP_DST;
            state_in = ST_DIVIDE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = est_ff;
               rsp_dist_in  = dist_ff;
               rsp_step_in  = step_ff;
               rsp_zero_in  = zflag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_SPD;
         reverse_ff    <= 1'b0;
         gear_ff       <= GEAR_RESET;
         circ_ff       <= CIRC_RESET;
         last_angle_ff <= '0;
         last_time_ff  <= '0;
         dist_ff       <= '0;
         est_ff        <= '0;
         p_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         reverse_ff    <= reverse_in;
         gear_ff       <= gear_in;
         circ_ff       <= circ_in;
         last_angle_ff <= last_angle_in;
         last_time_ff  <= last_time_in;
         dist_ff       <= dist_in;
         est_ff        <= est_in;
         p_ff          <= p_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
      step_ff      <= step_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      ang_ff       <= ang_in;
      now_ff       <= now_in;
      zflag_ff     <= zflag_in;
      u_ff         <= u_in;
      k_ff         <= k_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

endmodule

FILE: sv/eok_checker.sv
// ----------------------------------------------------------------------------
// eok_checker
// port-level assertions for the encoder odometry core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eok_checker #(
   parameter int ANGLE_BITS = 12
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [47:0]          rsp_distance,
   input logic signed [ANGLE_BITS:0]  rsp_angle_step
);

   localparam logic signed [ANGLE_BITS:0] HALF_C = (ANGLE_BITS+1)'(2 ** (ANGLE_BITS - 1));

   // held result transaction stays valid
   `EOK_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)

   // held result transaction keeps its distance
   `EOK_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_distance))

   // busy right after taking a transaction
   `EOK_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall)

   // unwrapped step stays within half a turn
   `EOK_ASSERT(a_step_range,
      rsp_valid |-> (rsp_angle_step <= HALF_C) && (rsp_angle_step >= -HALF_C))

endmodule

bind encoder_odometry_kalman_core eok_checker #(.ANGLE_BITS(ANGLE_BITS)) u_eok_checker (.*);
